// File: src/flr_pkg.sv
// flr_pkg: shared types and constants for the framed link receiver
// used by flr_front, flr_queue, flr_back and framed_link_receiver
`default_nettype none

package flr_pkg;

  // number of data bytes kept after the command byte
  localparam int unsigned KEY_BYTES = 5;
  localparam int unsigned KEY_W     = KEY_BYTES * 8;
  localparam int unsigned SLOT_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // header and frame position widths
  localparam int unsigned POS_W = 9;

  // queue between the parser and the frame checker
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // command codes
  localparam logic [7:0] CMD_ACK  = 8'd1;
  localparam logic [7:0] CMD_NACK = 8'd2;
  localparam logic [7:0] CMD_KEYS = 8'd3;

  // reply codes
  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NACK = 2'd2;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_CMD,
    KIND_DATA,
    KIND_CHECK
  } flr_kind_e;

  // one classified byte; value is the length for start, the byte otherwise
  typedef struct packed {
    flr_kind_e         kind;
    logic [7:0]        value;
    logic              store;
    logic [SLOT_W-1:0] slot;
  } flr_item_t;

endpackage

`default_nettype wire

// File: src/framed_link_receiver.sv
// framed_link_receiver: top level of the length framed link receiver
// depends on flr_pkg, flr_front, flr_queue and flr_back
//
// usage:
//   input channel: one link byte per request on rx_byte_i (in_valid_i /
//   in_ready_o). a frame is a length byte L, its complement, L payload
//   bytes (command first) and a modulo-256 checksum byte.
//   output channel: one request per frame on out_valid_o / out_ready_i
//   carrying pass/fail, command, length, key bytes, ack/nack flags, the
//   reply code and the wrapping bad frame count. header and payload bytes
//   give no result.
//   throughput: one byte per cycle while in_ready_o is high; the parser
//   classifies each byte as it arrives and the checker takes one queued
//   byte per cycle unless it holds at a checksum byte.
//   result: the accepted checksum byte goes into the queue, then through
//   the checker into the result register, which drives out_valid_o.
//   stall: while a result waits the checker still consumes payload bytes;
//   it holds only at the next checksum byte. the two entry queue then fills
//   and in_ready_o drops.
//   reset: rst_ni clears the header hunt, queue, sums and bad frame count;
//   the receiver starts hunting for a header right away.
`default_nettype none

module framed_link_receiver (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            rx_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       frame_ok_o,
  output logic [7:0]                 command_o,
  output logic [7:0]                 payload_length_o,
  output logic                       keys_valid_o,
  output logic [flr_pkg::KEY_W-1:0]  key_data_o,
  output logic                       ack_seen_o,
  output logic                       nack_seen_o,
  output logic [1:0]                 reply_due_o,
  output logic [31:0]                bad_frames_o
);
  import flr_pkg::*;

  logic      push;
  flr_item_t push_item;
  logic      q_ready;
  logic      q_valid;
  flr_item_t q_item;
  logic      q_pop;

  assign in_ready_o = q_ready;

  flr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .q_ready_i   (q_ready),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .push_item_o (push_item)
  );

  flr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  flr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ok_o       (frame_ok_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .keys_valid_o     (keys_valid_o),
    .key_data_o       (key_data_o),
    .ack_seen_o       (ack_seen_o),
    .nack_seen_o      (nack_seen_o),
    .reply_due_o      (reply_due_o),
    .bad_frames_o     (bad_frames_o)
  );

endmodule

`default_nettype wire

// File: src/flr_front.sv
// flr_front: header hunt and byte classification
// depends on flr_pkg
`default_nettype none

module flr_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               q_ready_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    push_o,
  output flr_pkg::flr_item_t      push_item_o
);
  import flr_pkg::*;

  logic [POS_W-1:0] position_q, position_d;
  logic [POS_W-1:0] total_q, total_d;
  logic [7:0]       first_q, first_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] k1;
  logic             accept;

  assign accept = in_valid_i && q_ready_i;
  assign pos    = position_q + POS_W'(1);
  assign k1     = pos - POS_W'(4);

  always_comb begin
    position_d        = position_q;
    total_d           = total_q;
    first_d           = first_q;
    found_d           = found_q;
    push_o            = 1'b0;
    push_item_o.kind  = KIND_DATA;
    push_item_o.value = rx_byte_i;
    push_item_o.store = 1'b0;
    push_item_o.slot  = k1[SLOT_W-1:0];
    if (accept) begin
      if (pos <= POS_W'(1) || (!found_q && pos > POS_W'(2))) begin
        first_d    = rx_byte_i;
        position_d = POS_W'(1);
        found_d    = 1'b0;
      end else if (pos == POS_W'(2)) begin
        if (rx_byte_i == ~first_q) begin
          total_d           = {1'b0, first_q} + POS_W'(3);
          found_d           = 1'b1;
          position_d        = POS_W'(2);
          push_o            = 1'b1;
          push_item_o.kind  = KIND_START;
          push_item_o.value = first_q;
        end else begin
          first_d    = rx_byte_i;
          position_d = POS_W'(1);
          found_d    = 1'b0;
        end
      end else if (pos < total_q) begin
        position_d = pos;
        push_o     = 1'b1;
        if (pos == POS_W'(3)) begin
          push_item_o.kind = KIND_CMD;
        end else begin
          push_item_o.kind  = KIND_DATA;
          // data slot counts from the byte after the command
          push_item_o.store = (k1 < POS_W'(KEY_BYTES));
        end
      end else begin
        // checksum byte closes the frame
        position_d       = '0;
        found_d          = 1'b0;
        push_o           = 1'b1;
        push_item_o.kind = KIND_CHECK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      total_q    <= '0;
      first_q    <= '0;
      found_q    <= 1'b0;
    end else begin
      position_q <= position_d;
      total_q    <= total_d;
      first_q    <= first_d;
      found_q    <= found_d;
    end
  end

endmodule

`default_nettype wire

// File: src/flr_queue.sv
// flr_queue: short fifo of classified bytes between parser and checker
// depends on flr_pkg
`default_nettype none

module flr_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire flr_pkg::flr_item_t push_item_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output flr_pkg::flr_item_t      item_o,
  input  wire logic               pop_i
);
  import flr_pkg::*;

  flr_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign ready_o = (count_q != QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/flr_back.sv
// flr_back: checksum, command and key capture, result register
// depends on flr_pkg
`default_nettype none

module flr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire flr_pkg::flr_item_t q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    frame_ok_o,
  output logic [7:0]              command_o,
  output logic [7:0]              payload_length_o,
  output logic                    keys_valid_o,
  output logic [flr_pkg::KEY_W-1:0] key_data_o,
  output logic                    ack_seen_o,
  output logic                    nack_seen_o,
  output logic [1:0]              reply_due_o,
  output logic [31:0]             bad_frames_o
);
  import flr_pkg::*;

  logic [7:0]       sum_q, sum_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       plen_q, plen_d;
  logic [KEY_W-1:0] keys_q, keys_d;
  logic [31:0]      err_q, err_d;
  logic             out_valid_q;
  logic             is_check, finish;
  logic             ok, is_ack, is_nack;
  logic [1:0]       reply;

  assign is_check = (q_item_i.kind == KIND_CHECK);
  assign q_pop_o  = q_valid_i && (!is_check || !out_valid_q || out_ready_i);
  assign finish   = q_pop_o && is_check;

  assign ok      = (sum_q == q_item_i.value);
  assign is_ack  = (cmd_q == CMD_ACK);
  assign is_nack = (cmd_q == CMD_NACK);
  assign reply   = (is_ack || is_nack) ? REPLY_NONE : (ok ? REPLY_ACK : REPLY_NACK);

  always_comb begin
    sum_d  = sum_q;
    cmd_d  = cmd_q;
    plen_d = plen_q;
    keys_d = keys_q;
    err_d  = err_q;
    if (q_pop_o) begin
      case (q_item_i.kind)
        KIND_START: begin
          sum_d  = '0;
          cmd_d  = '0;
          keys_d = '0;
          plen_d = q_item_i.value;
        end
        KIND_CMD: begin
          cmd_d = q_item_i.value;
          sum_d = sum_q + q_item_i.value;
        end
        KIND_DATA: begin
          sum_d = sum_q + q_item_i.value;
          for (int i = 0; i < KEY_BYTES; i++) begin
            // earliest data byte lands in the top lane
            if (q_item_i.store && q_item_i.slot == SLOT_W'(i)) begin
              keys_d[(KEY_BYTES-1-i)*8 +: 8] = q_item_i.value;
            end
          end
        end
        KIND_CHECK: begin
          if (!ok) begin
            err_d = err_q + 32'd1;
          end
        end
        default: begin
          sum_d = sum_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cmd_q       <= '0;
      plen_q      <= '0;
      keys_q      <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cmd_q  <= cmd_d;
      plen_q <= plen_d;
      keys_q <= keys_d;
      err_q  <= err_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded only when the previous result is gone
  always_ff @(posedge clk_i) begin
    if (finish) begin
      frame_ok_o       <= ok;
      command_o        <= cmd_q;
      payload_length_o <= plen_q;
      keys_valid_o     <= ok && (cmd_q == CMD_KEYS) && (plen_q == 8'(KEY_BYTES + 1));
      key_data_o       <= keys_q;
      ack_seen_o       <= ok && is_ack;
      nack_seen_o      <= ok && is_nack;
      reply_due_o      <= reply;
      bad_frames_o     <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
